### hw/rtl/pftb_pkg.sv
// ----------------------------------------------------------------------------
// Policer package
// Item kind codes and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package pftb_pkg;

  localparam logic [1:0] KIND_PACKET   = 2'd0;
  localparam logic [1:0] KIND_UE_LIMIT = 2'd1;
  localparam logic [1:0] KIND_SS_LIMIT = 2'd2;

  typedef struct packed {
    logic load;
    logic sel_sess;
    logic calc;
    logic add;
    logic chk_wr;
    logic lim_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic bucket_ok;
    logic out_busy;
  } status_t;

endpackage

### hw/rtl/pftb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pftb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pftb_ctrl.sv
// ----------------------------------------------------------------------------
// Policer controller
// Sequences the clearing pass, the two bucket updates of a packet and the
// read-modify-write of a limit item.
// ----------------------------------------------------------------------------
module pftb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_stall,
  input  pftb_pkg::status_t st,
  output pftb_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_LRD  = 4'd7;
  localparam logic [3:0] S_LWR  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.sel_sess = sel_r;
    unique case (state_r)
      S_CLR: begin
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            pftb_pkg::KIND_PACKET: begin
              sel_nxt   = 1'b0;
              state_nxt = S_RD;
            end
            pftb_pkg::KIND_UE_LIMIT: begin
              sel_nxt   = 1'b0;
              state_nxt = S_LRD;
            end
            pftb_pkg::KIND_SS_LIMIT: begin
              sel_nxt   = 1'b1;
              state_nxt = S_LRD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: state_nxt = S_CALC;
      S_CALC: begin
        cmd.calc = 1'b1;
        if (st.hit) begin
          state_nxt = S_ADD;
        end else if (sel_r) begin
          state_nxt = S_DONE;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk_wr = 1'b1;
        if (!st.bucket_ok || sel_r) begin
          state_nxt = S_DONE;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LRD: state_nxt = S_LWR;
      S_LWR: begin
        cmd.lim_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

### hw/rtl/pftb_dp.sv
// ----------------------------------------------------------------------------
// Policer datapath
// Item registers, the bucket RAMs and the shared refill and debit unit.
// ----------------------------------------------------------------------------
module pftb_dp #(
  parameter int UE_COUNT         = 64,
  parameter int SESSIONS_PER_UE  = 16,
  parameter int REFILL_PERIOD_MS = 1000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_direction,
  input  logic [5:0]        in_ue_index,
  input  logic [3:0]        in_psi,
  input  logic [15:0]       in_packet_bytes,
  input  logic [39:0]       in_new_limit,
  input  logic [47:0]       in_now_ms,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_allowed,
  input  pftb_pkg::cmd_t    cmd,
  output pftb_pkg::status_t st
);

  localparam int UE_SLOTS = 2 * UE_COUNT;
  localparam int SS_SLOTS = UE_SLOTS * SESSIONS_PER_UE;
  localparam int UAW      = $clog2(UE_SLOTS);
  localparam int SAW      = $clog2(SS_SLOTS);
  localparam int RPW      = $clog2(REFILL_PERIOD_MS + 1);
  localparam int TOKW     = 40 + RPW;
  localparam int NEEDW    = 16 + RPW;
  localparam int WW       = 1 + 40 + TOKW + 48;

  logic        dir_r;
  logic [5:0]  ue_r;
  logic [3:0]  psi_r;
  logic [15:0] bytes_r;
  logic [39:0] limit_r;
  logic [47:0] now_r;
  logic        pass_r;
  logic        out_valid_r;
  logic        out_allowed_r;
  logic [SAW-1:0] clr_r;
  logic        clearing_r;

  logic [39:0]     cap_r;
  logic [TOKW-1:0] tok_in_r, prod_r, full_r, tok_r;
  logic [47:0]     last_in_r, last_r;
  logic            gt_r;

  logic ue_ok, ss_ok;
  logic [31:0] ui_full, si_full;
  logic [UAW-1:0] ue_addr;
  logic [SAW-1:0] ss_addr;
  logic [WW-1:0] uq, sq, cur, wword;
  logic          cur_valid;
  logic [39:0]   cur_cap;
  logic [TOKW-1:0] cur_tok;
  logic [47:0]   cur_last;
  logic [47:0]   el_raw;
  logic [RPW-1:0] el_cl;
  logic [TOKW:0] sum;
  logic [TOKW-1:0] tok_ref, need, tok_out;
  logic          bucket_ok;
  logic          range_ok;
  logic          wr_en;
  logic          ue_we, ss_we;
  logic [UAW-1:0] ue_waddr;
  logic [SAW-1:0] ss_waddr;
  logic [WW-1:0] ue_wdata, ss_wdata;

  assign ue_ok    = 32'(ue_r) < UE_COUNT;
  assign ss_ok    = ue_ok && (32'(psi_r) < SESSIONS_PER_UE);
  assign ui_full  = 32'(dir_r) * UE_COUNT + 32'(ue_r);
  assign si_full  = ui_full * SESSIONS_PER_UE + 32'(psi_r);
  assign ue_addr  = ui_full[UAW-1:0];
  assign ss_addr  = si_full[SAW-1:0];
  assign range_ok = cmd.sel_sess ? ss_ok : ue_ok;

  assign cur = cmd.sel_sess ? sq : uq;
  assign {cur_valid, cur_cap, cur_tok, cur_last} = cur;

  assign el_raw = now_r - cur_last;
  assign el_cl  = (el_raw > 48'(REFILL_PERIOD_MS)) ? RPW'(REFILL_PERIOD_MS)
                                                   : el_raw[RPW-1:0];

  assign sum     = {1'b0, tok_in_r} + {1'b0, prod_r};
  assign tok_ref = !gt_r ? tok_in_r :
                   (sum < {1'b0, full_r}) ? sum[TOKW-1:0] : full_r;

  assign need      = TOKW'(NEEDW'(bytes_r) * NEEDW'(REFILL_PERIOD_MS));
  assign bucket_ok = tok_r >= need;
  assign tok_out   = bucket_ok ? tok_r - need : tok_r;

  always_comb begin
    if (!cmd.lim_wr) begin
      wword = {1'b1, cap_r, tok_out, last_r};
    end else if (limit_r == 40'd0) begin
      wword = {1'b0, cur_cap, cur_tok, cur_last};
    end else if (cur_valid) begin
      wword = {1'b1, limit_r, cur_tok, cur_last};
    end else begin
      wword = {1'b1, limit_r, TOKW'(limit_r) * TOKW'(REFILL_PERIOD_MS), now_r};
    end
  end

  assign wr_en    = (cmd.chk_wr || (cmd.lim_wr && range_ok));
  assign ue_we    = clearing_r ? (32'(clr_r) < UE_SLOTS) : (wr_en && !cmd.sel_sess);
  assign ss_we    = clearing_r ? 1'b1 : (wr_en && cmd.sel_sess);
  assign ue_waddr = clearing_r ? clr_r[UAW-1:0] : ue_addr;
  assign ss_waddr = clearing_r ? clr_r : ss_addr;
  assign ue_wdata = clearing_r ? '0 : wword;
  assign ss_wdata = clearing_r ? '0 : wword;

  pftb_ram #(.WIDTH(WW), .DEPTH(UE_SLOTS)) u_ue_ram (
    .clk(clk), .we(ue_we), .waddr(ue_waddr), .wdata(ue_wdata),
    .raddr(ue_addr), .rdata(uq)
  );

  pftb_ram #(.WIDTH(WW), .DEPTH(SS_SLOTS)) u_ss_ram (
    .clk(clk), .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
    .raddr(ss_addr), .rdata(sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r         <= '0;
      clearing_r    <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == SAW'(SS_SLOTS - 1)) clearing_r <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir_r   <= in_direction;
      ue_r    <= in_ue_index;
      psi_r   <= in_psi;
      bytes_r <= in_packet_bytes;
      limit_r <= in_new_limit;
      now_r   <= in_now_ms;
      pass_r  <= 1'b1;
    end
    if (cmd.calc) begin
      cap_r     <= cur_cap;
      tok_in_r  <= cur_tok;
      last_in_r <= cur_last;
      gt_r      <= now_r > cur_last;
      prod_r    <= TOKW'(el_cl) * TOKW'(cur_cap);
      full_r    <= TOKW'(cur_cap) * TOKW'(REFILL_PERIOD_MS);
    end
    if (cmd.add) begin
      tok_r  <= tok_ref;
      last_r <= gt_r ? now_r : last_in_r;
    end
    if (cmd.chk_wr) begin
      pass_r <= pass_r & bucket_ok;
    end
    if (cmd.out_load) begin
      out_allowed_r <= pass_r;
    end
  end

  assign st.clr_done  = clearing_r && (clr_r == SAW'(SS_SLOTS - 1));
  assign st.hit       = cur_valid && range_ok;
  assign st.bucket_ok = bucket_ok;
  assign st.out_busy  = out_valid_r && out_stall;

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;

endmodule

### hw/rtl/per_flow_token_bucket_policer.sv
// ----------------------------------------------------------------------------
// Per-flow token bucket policer
// A packet result follows its transfer after one read, refill multiply,
// saturating add and debit write for each valid bucket in one shared unit.
// No new item is taken until the result is loaded into the output register.
// A limit item takes a read and a write of its bucket RAM word. After reset a
// clearing pass empties the bucket RAMs, and no item is taken until it ends.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_policer #(
  parameter int UE_COUNT         = 64,
  parameter int SESSIONS_PER_UE  = 16,
  parameter int REFILL_PERIOD_MS = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic        in_direction,
  input  logic [5:0]  in_ue_index,
  input  logic [3:0]  in_psi,
  input  logic [15:0] in_packet_bytes,
  input  logic [39:0] in_new_limit,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_allowed
);

  pftb_pkg::cmd_t    cmd;
  pftb_pkg::status_t st;

  pftb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_kind(in_kind),
    .in_stall(in_stall), .st(st), .cmd(cmd)
  );

  pftb_dp #(
    .UE_COUNT(UE_COUNT), .SESSIONS_PER_UE(SESSIONS_PER_UE),
    .REFILL_PERIOD_MS(REFILL_PERIOD_MS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_direction(in_direction),
    .in_ue_index(in_ue_index), .in_psi(in_psi),
    .in_packet_bytes(in_packet_bytes), .in_new_limit(in_new_limit),
    .in_now_ms(in_now_ms), .out_stall(out_stall), .out_valid(out_valid),
    .out_allowed(out_allowed), .cmd(cmd), .st(st)
  );

endmodule
